[src/bfi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared sizes, command codes, instruction bytes and memory request types
// for the Brainfuck interpreter core.
// ----------------------------------------------------------------------------
package bfi_pkg;

  // Storage sizes
  localparam int unsigned TAPE_CELLS = 2048;
  localparam int unsigned PROG_DEPTH = 4096;

  // Derived widths
  localparam int unsigned TAPE_AW = $clog2(TAPE_CELLS);
  localparam int unsigned PROG_AW = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W    = $clog2(PROG_DEPTH + 1);
  localparam int unsigned NEST_W  = PC_W;

  // Request commands
  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // Instruction bytes
  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_INC   = 8'h2B;
  localparam logic [7:0] OP_DEC   = 8'h2D;
  localparam logic [7:0] OP_OUT   = 8'h2E;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  // Program store port request
  typedef struct packed {
    logic               we;
    logic [PROG_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PROG_AW-1:0] raddr;
  } prog_req_t;

  // Tape port request
  typedef struct packed {
    logic               we;
    logic [TAPE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [TAPE_AW-1:0] raddr;
  } tape_req_t;

endpackage

[src/bfi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data (read-first).
// ----------------------------------------------------------------------------
module bfi_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/bfi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_ctrl
// Sequencer: takes requests, fetches the instruction and current cell,
// updates the tape by read-modify-write, walks the program store for bracket
// matches and sweeps the tape clear after reset and on restart.
// ----------------------------------------------------------------------------
module bfi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         prog_byte_i,
  output logic               busy,
  output logic               done,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               halted_o,
  output logic               prog_full_o,
  output bfi_pkg::prog_req_t prog_req_o,
  input  logic [7:0]         prog_rdata_i,
  output bfi_pkg::tape_req_t tape_req_o,
  input  logic [7:0]         tape_rdata_i
);
  import bfi_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_EXEC   = 5'b00100,
    ST_SCAN_F = 5'b01000,
    ST_SCAN_B = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [PC_W-1:0]     len_q, len_d;
  logic [TAPE_AW-1:0]  dp_q, dp_d;
  logic [PC_W-1:0]     scan_q, scan_d;
  logic [NEST_W-1:0]   nest_q, nest_d;
  logic [TAPE_AW-1:0]  clr_q, clr_d;
  logic                rsp_q, rsp_d;
  logic                done_q, done_d;
  logic                outv_q, outv_d;
  logic [7:0]          outb_q, outb_d;
  logic                full_q, full_d;
  logic                accept;
  logic [PC_W-1:0]     praddr;

  assign accept = start && (state_q == ST_IDLE);

  // Main sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    len_d   = len_q;
    dp_d    = dp_q;
    scan_d  = scan_q;
    nest_d  = nest_q;
    clr_d   = clr_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    outv_d  = 1'b0;
    outb_d  = 8'h00;
    full_d  = 1'b0;
    prog_req_o.we    = 1'b0;
    prog_req_o.waddr = len_q[PROG_AW-1:0];
    prog_req_o.wdata = prog_byte_i;
    prog_req_o.raddr = praddr[PROG_AW-1:0];
    tape_req_o.we    = 1'b0;
    tape_req_o.waddr = dp_q;
    tape_req_o.wdata = 8'h00;
    tape_req_o.raddr = dp_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_APPEND: begin
              // Store the byte, or drop it when the store is full
              if (len_q < PC_W'(PROG_DEPTH)) begin
                prog_req_o.we = 1'b1;
                len_d = len_q + PC_W'(1);
              end else begin
                full_d = 1'b1;
              end
              done_d = 1'b1;
            end
            CMD_STEP: begin
              if (pc_q < len_q) begin
                state_d = ST_EXEC;
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_RESTART: begin
              pc_d    = '0;
              dp_d    = '0;
              clr_d   = '0;
              rsp_d   = 1'b1;
              state_d = ST_CLEAR;
            end
            default: begin
              len_d  = '0;
              pc_d   = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        // Zero one tape cell per cycle
        tape_req_o.we    = 1'b1;
        tape_req_o.waddr = clr_q;
        if (clr_q == TAPE_AW'(TAPE_CELLS - 1)) begin
          done_d  = rsp_q;
          rsp_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + TAPE_AW'(1);
        end
      end

      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        pc_d    = pc_q + PC_W'(1);
        case (prog_rdata_i)
          OP_RIGHT: begin
            dp_d = (dp_q == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : dp_q + TAPE_AW'(1);
          end
          OP_LEFT: begin
            dp_d = (dp_q == '0) ? TAPE_AW'(TAPE_CELLS - 1) : dp_q - TAPE_AW'(1);
          end
          OP_INC: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i + 8'd1;
          end
          OP_DEC: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i - 8'd1;
          end
          OP_OUT: begin
            outv_d = 1'b1;
            outb_d = tape_rdata_i;
          end
          OP_OPEN: begin
            // Zero cell: walk forward to the matching close bracket
            if (tape_rdata_i == 8'h00) begin
              pc_d    = pc_q;
              done_d  = 1'b0;
              nest_d  = NEST_W'(1);
              scan_d  = pc_q + PC_W'(1);
              state_d = ST_SCAN_F;
            end
          end
          OP_CLOSE: begin
            // Nonzero cell: walk back; a bracket at address zero has no partner
            if (tape_rdata_i != 8'h00) begin
              if (pc_q == '0) begin
                pc_d = '0;
              end else begin
                pc_d    = pc_q;
                done_d  = 1'b0;
                nest_d  = NEST_W'(1);
                scan_d  = pc_q - PC_W'(1);
                state_d = ST_SCAN_B;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN_F: begin
        if (scan_q >= len_q) begin
          // No partner: run off the end
          pc_d    = len_q;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (prog_rdata_i == OP_CLOSE && nest_q == NEST_W'(1)) begin
          pc_d    = scan_q + PC_W'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (prog_rdata_i == OP_OPEN) begin
            nest_d = nest_q + NEST_W'(1);
          end else if (prog_rdata_i == OP_CLOSE) begin
            nest_d = nest_q - NEST_W'(1);
          end
          scan_d = scan_q + PC_W'(1);
        end
      end

      ST_SCAN_B: begin
        if (prog_rdata_i == OP_OPEN && nest_q == NEST_W'(1)) begin
          pc_d    = scan_q + PC_W'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (scan_q == '0) begin
          // No partner: restart the run from address zero
          pc_d    = '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (prog_rdata_i == OP_CLOSE) begin
            nest_d = nest_q + NEST_W'(1);
          end else if (prog_rdata_i == OP_OPEN) begin
            nest_d = nest_q - NEST_W'(1);
          end
          scan_d = scan_q - PC_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Program read address: current instruction, or the next byte of a scan
  always_comb begin
    case (state_q)
      ST_EXEC:   praddr = (prog_rdata_i == OP_CLOSE) ? pc_q - PC_W'(1) : pc_q + PC_W'(1);
      ST_SCAN_F: praddr = scan_q + PC_W'(1);
      ST_SCAN_B: praddr = scan_q - PC_W'(1);
      default:   praddr = pc_q;
    endcase
  end

  // Control registers; reset starts with a tape sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pc_q    <= '0;
      len_q   <= '0;
      dp_q    <= '0;
      scan_q  <= '0;
      nest_q  <= '0;
      clr_q   <= '0;
      rsp_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      len_q   <= len_d;
      dp_q    <= dp_d;
      scan_q  <= scan_d;
      nest_q  <= nest_d;
      clr_q   <= clr_d;
      rsp_q   <= rsp_d;
      done_q  <= done_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    outv_q <= outv_d;
    outb_q <= outb_d;
    full_q <= full_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign done        = done_q;
  assign out_valid_o = outv_q;
  assign out_byte_o  = outb_q;
  assign prog_full_o = full_q;
  assign halted_o    = (pc_q >= len_q);

endmodule

[src/brainfuck_interpreter_core_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_top
// Brainfuck machine with an 8-bit tape and a stored program, driven by
// append / step / restart / clear requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  request   in         start & !busy        cmd_i, prog_byte_i
//  result    out        done (one cycle)     out_valid_o, out_byte_o,
//                                            halted_o, prog_full_o
//
// Append, clear and a step at end of program: result in the cycle after the request.
// A step reads program and tape memory, then writes back.
// A bracket jump walks the program store one byte at a time past the bracket;
// a forward scan with no partner stops at the end of the program.
// Restart sweeps the tape one cell per cycle, then gives its result.
// After reset the same sweep runs with busy high.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd_i,
  input  logic [7:0] prog_byte_i,
  output logic       done,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       halted_o,
  output logic       prog_full_o
);
  import bfi_pkg::*;

  prog_req_t  prog_req;
  tape_req_t  tape_req;
  logic [7:0] prog_rdata;
  logic [7:0] tape_rdata;

  // Sequencer
  bfi_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .prog_byte_i  (prog_byte_i),
    .busy         (busy),
    .done         (done),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .halted_o     (halted_o),
    .prog_full_o  (prog_full_o),
    .prog_req_o   (prog_req),
    .prog_rdata_i (prog_rdata),
    .tape_req_o   (tape_req),
    .tape_rdata_i (tape_rdata)
  );

  // Program store
  bfi_ram #(
    .Depth (PROG_DEPTH),
    .Width (8)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_req.we),
    .waddr_i (prog_req.waddr),
    .wdata_i (prog_req.wdata),
    .raddr_i (prog_req.raddr),
    .rdata_o (prog_rdata)
  );

  // Tape
  bfi_ram #(
    .Depth (TAPE_CELLS),
    .Width (8)
  ) u_tape_ram (
    .clk_i   (clk_i),
    .we_i    (tape_req.we),
    .waddr_i (tape_req.waddr),
    .wdata_i (tape_req.wdata),
    .raddr_i (tape_req.raddr),
    .rdata_o (tape_rdata)
  );

  // A result always leaves the block ready for the next request
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy)
    else $error("result shown while busy");

  // Output bytes and full flags only travel with a result
  a_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o || prog_full_o) |-> done)
    else $error("result flag without strobe");

  // The tape is written only inside a step or a sweep
  a_tape_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape_req.we |-> busy)
    else $error("tape write while idle");

  // A restart always enters the sweep
  a_restart_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_RESTART) |=> (busy && !done))
    else $error("restart did not start the tape sweep");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for brainfuck_interpreter_core_top. Requests enter
// through the start/busy handshake in bursts with random gaps. Each accepted
// request updates a private copy of the interpreter state (program store,
// tape, program counter, data pointer), which gives the expected result.
// Every done strobe is then compared field by field against the oldest
// pending expectation. Directed tests cover program load, cell and pointer
// wrap, loops and unmatched brackets, and restart.
// Random programs with random content follow.
// ----------------------------------------------------------------------------
module testbench;
  import bfi_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1780;
  localparam int unsigned DRAIN_CYCLES    = 100;

  typedef struct {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    logic       prog_full;
    time        stamp;
  } bf_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic [1:0] cmd_i       = CMD_APPEND;
  logic [7:0] prog_byte_i = 8'h00;
  logic       busy;
  logic       done;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       halted_o;
  logic       prog_full_o;

  // Interpreter state as seen by the bench
  logic [7:0]  tape_q [TAPE_CELLS];
  logic [7:0]  code_q [PROG_DEPTH];
  int unsigned code_len;
  int unsigned pc_q;
  int unsigned ptr_q;

  bf_result_t  pending_q [$];
  bf_result_t  head;
  int unsigned n_requests  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_bytes_out = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_fail      = 0;
  int unsigned burst_left  = 1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  brainfuck_interpreter_core_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .prog_byte_i (prog_byte_i),
    .done        (done),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .halted_o    (halted_o),
    .prog_full_o (prog_full_o)
  );

  // Jump past the matching close bracket, or to the end of the program
  function automatic void seek_close();
    int unsigned a;
    int unsigned nest;
    nest = 0;
    for (a = pc_q; a < code_len; a++) begin
      if (code_q[a] == OP_OPEN) begin
        nest++;
      end else if (code_q[a] == OP_CLOSE) begin
        if (nest != 0) nest--;
        if (nest == 0) begin
          pc_q = a + 1;
          return;
        end
      end
    end
    pc_q = code_len;
  endfunction

  // Jump back just past the matching open bracket, or to address 0
  function automatic void seek_open();
    int unsigned a;
    int unsigned nest;
    nest = 0;
    for (a = pc_q + 1; a > 0; a--) begin
      if (code_q[a-1] == OP_CLOSE) begin
        nest++;
      end else if (code_q[a-1] == OP_OPEN) begin
        if (nest != 0) nest--;
        if (nest == 0) begin
          pc_q = a;
          return;
        end
      end
    end
    pc_q = 0;
  endfunction

  // Apply one request to the bench state and return the result it must give
  function automatic bf_result_t predict_request(cmd_e c, logic [7:0] b);
    bf_result_t r;
    logic [7:0] op;
    logic [7:0] cur;
    r.out_valid = 1'b0;
    r.out_byte  = 8'h00;
    r.prog_full = 1'b0;
    r.stamp     = $time;
    case (c)
      CMD_APPEND: begin
        if (code_len < PROG_DEPTH) begin
          code_q[code_len] = b;
          code_len++;
        end else begin
          r.prog_full = 1'b1;
        end
      end
      CMD_STEP: begin
        if (pc_q < code_len) begin
          op  = code_q[pc_q];
          cur = tape_q[ptr_q];
          case (op)
            OP_RIGHT: begin
              ptr_q = (ptr_q == TAPE_CELLS - 1) ? 0 : ptr_q + 1;
              pc_q++;
            end
            OP_LEFT: begin
              ptr_q = (ptr_q == 0) ? TAPE_CELLS - 1 : ptr_q - 1;
              pc_q++;
            end
            OP_INC: begin
              tape_q[ptr_q] = cur + 8'd1;
              pc_q++;
            end
            OP_DEC: begin
              tape_q[ptr_q] = cur - 8'd1;
              pc_q++;
            end
            OP_OUT: begin
              r.out_valid = 1'b1;
              r.out_byte  = cur;
              pc_q++;
            end
            OP_OPEN: begin
              if (cur == 8'h00) seek_close();
              else pc_q++;
            end
            OP_CLOSE: begin
              if (cur != 8'h00) seek_open();
              else pc_q++;
            end
            default: pc_q++;
          endcase
        end
      end
      CMD_RESTART: begin
        foreach (tape_q[i]) tape_q[i] = 8'h00;
        pc_q  = 0;
        ptr_q = 0;
      end
      default: begin
        code_len = 0;
        pc_q     = 0;
      end
    endcase
    r.halted = (pc_q >= code_len);
    return r;
  endfunction

  task automatic report_failure(string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endtask

  // Offer one request, hold it until accepted, then maybe end the burst
  task automatic issue_request(cmd_e c, logic [7:0] b);
    start       <= 1'b1;
    cmd_i       <= c;
    prog_byte_i <= b;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pending_q.push_back(predict_request(c, b));
    n_requests++;
    burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Drop start and wait for every pending result
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_program(string s);
    int i;
    for (i = 0; i < s.len(); i++) issue_request(CMD_APPEND, s[i]);
  endtask

  // Step until the program halts or the step limit runs out
  task automatic run_steps(int unsigned limit);
    while (limit != 0 && pc_q < code_len) begin
      issue_request(CMD_STEP, 8'($urandom_range(0, 255)));
      limit--;
    end
  endtask

  function automatic logic [7:0] pick_instruction();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return OP_INC;
      4, 5, 6:    return OP_DEC;
      7, 8:       return OP_RIGHT;
      9, 10:      return OP_LEFT;
      11, 12, 13: return OP_OUT;
      14, 15:     return OP_OPEN;
      16, 17:     return OP_CLOSE;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Empty program, no-op bytes at both extremes, stepping past the end
  task automatic test_program_store();
    issue_request(CMD_CLEAR, 8'hFF);
    issue_request(CMD_STEP, 8'hA5);
    issue_request(CMD_APPEND, 8'h00);
    issue_request(CMD_APPEND, 8'hFF);
    issue_request(CMD_APPEND, 8'h7A);
    run_steps(3);
    issue_request(CMD_STEP, 8'h00);
    issue_request(CMD_CLEAR, 8'h55);
    wait_idle();
  endtask

  // Decrement below zero and increment back through 255
  task automatic test_cell_wrap();
    load_program("-.+.+.");
    run_steps(8);
    issue_request(CMD_CLEAR, 8'h00);
    wait_idle();
  endtask

  // Move left of cell 0 and back
  task automatic test_pointer_wrap();
    load_program("<+.>.<-.");
    run_steps(10);
    issue_request(CMD_CLEAR, 8'h00);
    wait_idle();
  endtask

  // Skipped loop, counted loop, nested loop, unmatched brackets both ways
  task automatic test_loops();
    load_program(">>>[+.]++[-.]>+[[-]].");
    run_steps(60);
    issue_request(CMD_CLEAR, 8'h00);
    load_program("[+.");
    run_steps(4);
    issue_request(CMD_STEP, 8'h00);
    issue_request(CMD_CLEAR, 8'h00);
    load_program("+].");
    run_steps(5);
    issue_request(CMD_CLEAR, 8'h00);
    wait_idle();
  endtask

  // Restart clears the tape and rewinds but keeps the program
  task automatic test_restart();
    load_program("+>++.<.");
    run_steps(10);
    issue_request(CMD_RESTART, 8'hFF);
    run_steps(10);
    issue_request(CMD_RESTART, 8'h00);
    issue_request(CMD_STEP, 8'h3C);
    issue_request(CMD_CLEAR, 8'h00);
    wait_idle();
  endtask

  // Clear, load a short program (mostly balanced), run it for a while
  task automatic random_episode();
    int unsigned len;
    int unsigned open_cnt;
    int unsigned budget;
    int unsigned i;
    bit          broken;
    logic [7:0]  b;
    if ($urandom_range(0, 9) == 0) issue_request(CMD_RESTART, 8'($urandom_range(0, 255)));
    issue_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
    len      = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    broken   = ($urandom_range(0, 7) == 0);
    open_cnt = 0;
    for (i = 0; i < len; i++) begin
      b = pick_instruction();
      if (!broken) begin
        if (open_cnt == len - i) b = OP_CLOSE;
        else if (b == OP_OPEN && open_cnt + 1 > len - i - 1) b = OP_INC;
        else if (b == OP_CLOSE && open_cnt == 0) b = OP_DEC;
      end
      if (b == OP_OPEN) open_cnt++;
      else if (b == OP_CLOSE && open_cnt != 0) open_cnt--;
      issue_request(CMD_APPEND, b);
    end
    budget = $urandom_range(len, 6 * len + 10);
    while (budget != 0 && pc_q < code_len) begin
      case ($urandom_range(0, 39))
        0:       issue_request(CMD_APPEND, pick_instruction());
        1:       issue_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
        default: issue_request(CMD_STEP, 8'($urandom_range(0, 255)));
      endcase
      budget--;
    end
    if ($urandom_range(0, 2) == 0) issue_request(CMD_STEP, 8'($urandom_range(0, 255)));
  endtask

  // Loose mix of commands with arbitrary bytes
  task automatic random_noise();
    repeat ($urandom_range(4, 16)) begin
      case ($urandom_range(0, 15))
        0:             issue_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
        1, 2, 3, 4, 5: issue_request(CMD_APPEND, 8'($urandom_range(0, 255)));
        default:       issue_request(CMD_STEP, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_random_programs();
    int unsigned first;
    first = n_requests;
    while (n_requests - first < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) == 0) random_noise();
      else random_episode();
    end
    wait_idle();
  endtask

  // Compare each result against the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && done === 1'b1) begin
      if (pending_q.size() == 0 || pending_q[0].stamp == $time) begin
        report_failure($sformatf("%0t: result with no request pending", $time));
      end else begin
        head = pending_q.pop_front();
        n_checked++;
        if (out_valid_o === 1'b1) n_bytes_out++;
        if (prog_full_o === 1'b1) n_dropped++;
        if (out_valid_o !== head.out_valid || out_byte_o !== head.out_byte ||
            halted_o !== head.halted || prog_full_o !== head.prog_full) begin
          report_failure({
            $sformatf("%0t: result %0d expected valid=%0b byte=%02h halted=%0b full=%0b",
                      $time, n_checked, head.out_valid, head.out_byte, head.halted,
                      head.prog_full),
            $sformatf(", got valid=%0b byte=%02h halted=%0b full=%0b",
                      out_valid_o, out_byte_o, halted_o, prog_full_o)});
        end
      end
    end
  end

  initial begin
    foreach (tape_q[i]) tape_q[i] = 8'h00;
    code_len = 0;
    pc_q     = 0;
    ptr_q    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_program_store();
    test_cell_wrap();
    test_pointer_wrap();
    test_loops();
    test_restart();
    test_random_programs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d mismatches.",
             n_requests, n_checked, n_fail);
    $display("Saw %0d output bytes and %0d dropped appends.", n_bytes_out, n_dropped);
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Timeout with %0d results pending", pending_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
src/bfi_pkg.sv
src/bfi_ram.sv
src/bfi_ctrl.sv
src/brainfuck_interpreter_core_top.sv
sim/testbench.sv
